[rtl/knee_tone_curve_with_desaturation_unit_macros.svh]
// ----------------------------------------------------------------------------
// Knee tone curve unit assertion macros
// Shared concurrent assertion forms for the tone curve unit.
// ----------------------------------------------------------------------------
`ifndef KNEE_TONE_CURVE_WITH_DESATURATION_UNIT_MACROS_SVH
`define KNEE_TONE_CURVE_WITH_DESATURATION_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tone curve assertion failed");

// Next-cycle implication, disabled during reset.
`define KTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tone curve assertion failed");

`endif

[rtl/ktc_pkg.sv]
// ----------------------------------------------------------------------------
// Knee tone curve package
// Item types, register indexes and datapath widths of the tone curve unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ktc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_LINEAR_MODE = 3'd0;
    localparam logic [2:0] CFG_SRC_KNEE    = 3'd1;
    localparam logic [2:0] CFG_DST_KNEE    = 3'd2;
    localparam logic [2:0] CFG_PA          = 3'd3;
    localparam logic [2:0] CFG_SLOPE       = 3'd4;
    localparam logic [2:0] CFG_QA          = 3'd5;
    localparam logic [2:0] CFG_QB          = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Curve datapath widths.
    localparam int X_W    = 18;
    localparam int ACC_W  = 36;
    localparam int PROD_W = ACC_W + X_W;

    // 3.0 in Q2.16, the hull offset.
    localparam logic [17:0] HULL_THREE = 18'd196608;

    // Divider: 53-bit remainder, 17 quotient bits, one per stage.
    localparam int DIV_W     = 53;
    localparam int DIV_STEPS = 17;

    typedef struct packed {
        logic        [15:0] intensity_in;
        logic signed [15:0] chroma_p_in;
        logic signed [15:0] chroma_t_in;
    } t_pix_in;

    typedef struct packed {
        logic        [15:0] intensity_out;
        logic signed [15:0] chroma_p_out;
        logic signed [15:0] chroma_t_out;
        logic        [15:0] desat_factor;
    } t_pix_out;

    typedef struct packed {
        logic [DIV_W-1:0]     rem;
        logic [DIV_W-1:0]     den;
        logic [DIV_STEPS-1:0] quo;
        logic                 sat;
    } t_div_stage;

    typedef struct packed {
        logic               zero;
        logic        [15:0] iout;
        logic signed [15:0] chroma_p;
        logic signed [15:0] chroma_t;
    } t_side;

endpackage

`default_nettype wire

[rtl/ktc_div_pipe.sv]
// ----------------------------------------------------------------------------
// Pipelined Q1.16 ratio divider
// Restoring division, one quotient bit per stage, with an overflow flag
// for ratios of two or more.
// ----------------------------------------------------------------------------
`default_nettype none

module ktc_div_pipe import ktc_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic [DIV_W-1:0]     i_num,
    input  wire logic [DIV_W-1:0]     i_den,
    output logic      [DIV_STEPS-1:0] o_quo,
    output logic                      o_sat
);

    t_div_stage r_stg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [DIV_W-1:0]     w_trial;
        logic [DIV_W-1:0]     w_den;
        logic [DIV_STEPS-1:0] w_quo;
        logic                 w_sat;
        logic                 w_bit;

        // The first step takes the integer bit straight from the numerator.
        if (k == 0) begin : g_first
            assign w_trial = i_num;
            assign w_den   = i_den;
            assign w_quo   = '0;
            assign w_sat   = (i_num >= {i_den[DIV_W-2:0], 1'b0});
        end else begin : g_next
            assign w_trial = {r_stg[k-1].rem[DIV_W-2:0], 1'b0};
            assign w_den   = r_stg[k-1].den;
            assign w_quo   = r_stg[k-1].quo;
            assign w_sat   = r_stg[k-1].sat;
        end

        assign w_bit = (w_trial >= w_den);

        // Subtract when the divisor fits and shift in the quotient bit.
        always_ff @(posedge i_clk) begin
            r_stg[k].rem <= w_bit ? (w_trial - w_den) : w_trial;
            r_stg[k].den <= w_den;
            r_stg[k].quo <= {w_quo[DIV_STEPS-2:0], w_bit};
            r_stg[k].sat <= w_sat;
        end
    end

    assign o_quo = r_stg[DIV_STEPS-1].quo;
    assign o_sat = r_stg[DIV_STEPS-1].sat;

endmodule

`default_nettype wire

[rtl/knee_tone_curve_with_desaturation_unit.sv]
// ----------------------------------------------------------------------------
// Knee tone curve with desaturation
// Maps IPT intensity through a knee polynomial or linear curve and scales
// chroma by the desaturation factor.
// ----------------------------------------------------------------------------
// The unit takes one pixel in every clock cycle and never raises busy. The
// result of each item is on the outputs, marked by a one-cycle strobe on
// o_valid, after it has passed stages A to H, the dividers, J and K. The
// receiver cannot stall it, so it must take every result. The latency is
// set mostly by the two 17-stage ratio dividers, which produce one quotient
// bit per stage. Configuration must be written only while no item is in
// flight; the unit does not enforce this. The configuration port is always ready.
`default_nettype none

`include "knee_tone_curve_with_desaturation_unit_macros.svh"

module knee_tone_curve_with_desaturation_unit import ktc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_pix_in               i_pixel,
    output logic                       o_valid,
    output t_pix_out                   o_result,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic               r_linear;
    logic        [15:0] r_src_knee;
    logic signed [16:0] r_dst_knee;
    logic signed [31:0] r_pa;
    logic signed [31:0] r_slope;
    logic signed [31:0] r_qa;
    logic signed [31:0] r_qb;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linear   <= 1'b0;
            r_src_knee <= 16'd32768;
            r_dst_knee <= 17'sd32768;
            r_pa       <= '0;
            r_slope    <= 32'sd65536;
            r_qa       <= '0;
            r_qb       <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LINEAR_MODE: r_linear   <= i_cfg_data[0];
                CFG_SRC_KNEE:    r_src_knee <= i_cfg_data[15:0];
                CFG_DST_KNEE:    r_dst_knee <= i_cfg_data[16:0];
                CFG_PA:          r_pa       <= i_cfg_data;
                CFG_SLOPE:       r_slope    <= i_cfg_data;
                CFG_QA:          r_qa       <= i_cfg_data;
                CFG_QB:          r_qb       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [ACC_W-1:0] w_dk_ext;
    logic signed [ACC_W-1:0] w_slope_ext;
    logic signed [ACC_W-1:0] w_qb_ext;
    assign w_dk_ext    = ACC_W'(r_dst_knee);
    assign w_slope_ext = ACC_W'(r_slope);
    assign w_qb_ext    = ACC_W'(r_qb);

    // Valid bits of the curve and hull stages: A through H.
    logic [7:0] r_vld;
    logic       w_accept;
    assign w_accept = start && !busy;

    // Stage A: first product, coefficient times x or slope times intensity.
    logic signed [X_W-1:0]  w_x;
    logic signed [31:0]     w_coef;
    logic signed [X_W-1:0]  w_op;
    logic signed [49:0]     w_prod_a;
    assign w_x      = $signed({2'b00, i_pixel.intensity_in}) - $signed({2'b00, r_src_knee});
    assign w_coef   = r_linear ? r_slope : ((w_x > 0) ? r_qa : r_pa);
    assign w_op     = r_linear ? $signed({2'b00, i_pixel.intensity_in}) : w_x;
    assign w_prod_a = w_coef * w_op;

    logic signed [49:0]    r_a_prod;
    logic signed [X_W-1:0] r_a_x;
    logic                  r_a_pos;
    t_pix_in               r_a_pix;

    always_ff @(posedge i_clk) begin
        r_a_prod <= w_prod_a;
        r_a_x    <= w_x;
        r_a_pos  <= !r_linear && (w_x > 0);
        r_a_pix  <= i_pixel;
    end

    // Stage B: round and add qb, slope or the linear offset.
    logic signed [49:0]      w_rnd_b;
    logic signed [ACC_W-1:0] w_add_b;
    assign w_rnd_b = (r_a_prod + 50'sd32768) >>> 16;
    assign w_add_b = r_linear ? w_dk_ext : (r_a_pos ? w_qb_ext : w_slope_ext);

    logic signed [ACC_W-1:0] r_b_acc;
    logic signed [X_W-1:0]   r_b_x;
    logic                    r_b_pos;
    t_pix_in                 r_b_pix;

    always_ff @(posedge i_clk) begin
        r_b_acc <= w_rnd_b[ACC_W-1:0] + w_add_b;
        r_b_x   <= r_a_x;
        r_b_pos <= r_a_pos;
        r_b_pix <= r_a_pix;
    end

    // Stage C: accumulator times x.
    logic signed [PROD_W-1:0] r_c_prod;
    logic signed [ACC_W-1:0]  r_c_acc;
    logic signed [X_W-1:0]    r_c_x;
    logic                     r_c_pos;
    t_pix_in                  r_c_pix;

    always_ff @(posedge i_clk) begin
        r_c_prod <= r_b_acc * r_b_x;
        r_c_acc  <= r_b_acc;
        r_c_x    <= r_b_x;
        r_c_pos  <= r_b_pos;
        r_c_pix  <= r_b_pix;
    end

    // Stage D: above the knee add slope, below it this is the final sum; linear mode passes the stage B sum.
    logic signed [PROD_W-1:0] w_rnd_d;
    logic signed [ACC_W-1:0]  w_sum_d;
    assign w_rnd_d = (r_c_prod + PROD_W'(32768)) >>> 16;
    assign w_sum_d = w_rnd_d[ACC_W-1:0] + (r_c_pos ? w_slope_ext : w_dk_ext);

    logic signed [ACC_W-1:0] r_d_acc;
    logic signed [X_W-1:0]   r_d_x;
    logic                    r_d_pos;
    t_pix_in                 r_d_pix;

    always_ff @(posedge i_clk) begin
        r_d_acc <= r_linear ? r_c_acc : w_sum_d;
        r_d_x   <= r_c_x;
        r_d_pos <= r_c_pos;
        r_d_pix <= r_c_pix;
    end

    // Stage E: last Horner product above the knee.
    logic signed [PROD_W-1:0] r_e_prod;
    logic signed [ACC_W-1:0]  r_e_acc;
    logic                     r_e_pos;
    t_pix_in                  r_e_pix;

    always_ff @(posedge i_clk) begin
        r_e_prod <= r_d_acc * r_d_x;
        r_e_acc  <= r_d_acc;
        r_e_pos  <= r_d_pos;
        r_e_pix  <= r_d_pix;
    end

    // Stage F: final sum and clamp of the mapped intensity.
    logic signed [PROD_W-1:0] w_rnd_f;
    logic signed [ACC_W-1:0]  w_y;
    logic        [15:0]       w_iout;
    assign w_rnd_f = (r_e_prod + PROD_W'(32768)) >>> 16;
    assign w_y     = r_e_pos ? (w_rnd_f[ACC_W-1:0] + w_dk_ext) : r_e_acc;

    always_comb begin
        if (w_y < 0) begin
            w_iout = 16'd0;
        end else if (w_y > 65535) begin
            w_iout = 16'hFFFF;
        end else begin
            w_iout = w_y[15:0];
        end
    end

    logic [15:0] r_f_iout;
    t_pix_in     r_f_pix;

    always_ff @(posedge i_clk) begin
        r_f_iout <= w_iout;
        r_f_pix  <= r_e_pix;
    end

    // Stage G: squares of 3 minus each intensity.
    logic [17:0] w_d_out;
    logic [17:0] w_d_in;
    assign w_d_out = HULL_THREE - {2'b00, r_f_iout};
    assign w_d_in  = HULL_THREE - {2'b00, r_f_pix.intensity_in};

    logic [35:0] r_g_dd_out;
    logic [35:0] r_g_dd_in;
    logic [15:0] r_g_iout;
    t_pix_in     r_g_pix;

    always_ff @(posedge i_clk) begin
        r_g_dd_out <= w_d_out * w_d_out;
        r_g_dd_in  <= w_d_in * w_d_in;
        r_g_iout   <= r_f_iout;
        r_g_pix    <= r_f_pix;
    end

    // Stage H: hull values of both intensities.
    logic [51:0] r_h_hull_out;
    logic [51:0] r_h_hull_in;
    t_side       r_h_side;
    logic [15:0] r_h_iin;

    always_ff @(posedge i_clk) begin
        r_h_hull_out      <= r_g_dd_out * r_g_iout;
        r_h_hull_in       <= r_g_dd_in * r_g_pix.intensity_in;
        r_h_iin           <= r_g_pix.intensity_in;
        r_h_side.zero     <= (r_g_iout == 16'd0) || (r_g_pix.intensity_in == 16'd0);
        r_h_side.iout     <= r_g_iout;
        r_h_side.chroma_p <= r_g_pix.chroma_p_in;
        r_h_side.chroma_t <= r_g_pix.chroma_t_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[6:0], w_accept};
        end
    end

    // Ratio dividers: intensity ratio and inverse hull ratio.
    logic [DIV_STEPS-1:0] w_quo_int;
    logic                 w_sat_int;
    logic [DIV_STEPS-1:0] w_quo_hull;
    logic                 w_sat_hull;

    ktc_div_pipe u_div_int (
        .i_clk (i_clk),
        .i_num (DIV_W'(r_h_iin)),
        .i_den (DIV_W'(r_h_side.iout)),
        .o_quo (w_quo_int),
        .o_sat (w_sat_int)
    );

    ktc_div_pipe u_div_hull (
        .i_clk (i_clk),
        .i_num (DIV_W'(r_h_hull_out)),
        .i_den (DIV_W'(r_h_hull_in)),
        .o_quo (w_quo_hull),
        .o_sat (w_sat_hull)
    );

    // Side data travels beside the dividers.
    t_side                r_dly     [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_dly_vld;

    always_ff @(posedge i_clk) begin
        r_dly[0] <= r_h_side;
        for (int i = 1; i < DIV_STEPS; i++) begin
            r_dly[i] <= r_dly[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly_vld <= '0;
        end else begin
            r_dly_vld <= {r_dly_vld[DIV_STEPS-2:0], r_vld[7]};
        end
    end

    // Stage J: round both ratios, take the smaller, force zero intensities.
    // The rounding add is one bit wider so that a full quotient carries
    // into the top bit and saturates.
    logic [DIV_STEPS-1:0] w_rq_int;
    logic [DIV_STEPS-1:0] w_rq_hull;
    logic [15:0]          w_r1;
    logic [15:0]          w_r2;
    logic [15:0]          w_factor;
    t_side                w_side_j;

    assign w_side_j  = r_dly[DIV_STEPS-1];
    assign w_rq_int  = DIV_STEPS'(({1'b0, w_quo_int} + (DIV_STEPS+1)'(1)) >> 1);
    assign w_rq_hull = DIV_STEPS'(({1'b0, w_quo_hull} + (DIV_STEPS+1)'(1)) >> 1);
    assign w_r1 = (w_sat_int || w_rq_int[DIV_STEPS-1]) ? 16'hFFFF : w_rq_int[15:0];
    assign w_r2 = (w_sat_hull || w_rq_hull[DIV_STEPS-1]) ? 16'hFFFF : w_rq_hull[15:0];

    always_comb begin
        if (w_side_j.zero) begin
            w_factor = 16'd0;
        end else if (w_r1 < w_r2) begin
            w_factor = w_r1;
        end else begin
            w_factor = w_r2;
        end
    end

    logic        r_j_vld;
    logic [15:0] r_j_factor;
    t_side       r_j_side;

    always_ff @(posedge i_clk) begin
        r_j_factor <= w_factor;
        r_j_side   <= w_side_j;
    end

    // Stage K: scale chroma by the factor, round and saturate.
    logic signed [32:0] w_prod_p;
    logic signed [32:0] w_prod_t;
    logic signed [32:0] w_rnd_p;
    logic signed [32:0] w_rnd_t;
    logic signed [15:0] w_cp;
    logic signed [15:0] w_ct;

    assign w_prod_p = r_j_side.chroma_p * $signed({1'b0, r_j_factor});
    assign w_prod_t = r_j_side.chroma_t * $signed({1'b0, r_j_factor});
    assign w_rnd_p  = (w_prod_p + 33'sd16384) >>> 15;
    assign w_rnd_t  = (w_prod_t + 33'sd16384) >>> 15;

    always_comb begin
        if (w_rnd_p > 32767) begin
            w_cp = 16'sh7FFF;
        end else if (w_rnd_p < -32768) begin
            w_cp = 16'sh8000;
        end else begin
            w_cp = w_rnd_p[15:0];
        end
        if (w_rnd_t > 32767) begin
            w_ct = 16'sh7FFF;
        end else if (w_rnd_t < -32768) begin
            w_ct = 16'sh8000;
        end else begin
            w_ct = w_rnd_t[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_result.intensity_out <= r_j_side.iout;
        o_result.chroma_p_out  <= w_cp;
        o_result.chroma_t_out  <= w_ct;
        o_result.desat_factor  <= r_j_factor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_vld <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_j_vld <= r_dly_vld[DIV_STEPS-1];
            o_valid <= r_j_vld;
        end
    end

    // A dark output pixel carries no chroma, and a zero factor clears it.
    `KTC_ASSERT_IMP(a_dark_no_factor, i_clk, i_rst_n, o_valid && (o_result.intensity_out == 16'd0), o_result.desat_factor == 16'd0)
    `KTC_ASSERT_IMP(a_zero_factor_no_chroma, i_clk, i_rst_n, o_valid && (o_result.desat_factor == 16'd0), (o_result.chroma_p_out == 16'sd0) && (o_result.chroma_t_out == 16'sd0))
    `KTC_ASSERT_NEXT(a_slope_write, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_SLOPE), r_slope == $past(i_cfg_data))

endmodule

`default_nettype wire

[tb/tb_knee_tone_curve_with_desaturation_unit.sv]
// ----------------------------------------------------------------------------
// Knee tone curve unit testbench
// Drives pixels in bursts through several curve settings: reset values,
// extreme coefficients and random ones. Every result is checked field by
// field against a stored value or a fixed-point model of the curve and the desaturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_knee_tone_curve_with_desaturation_unit import ktc_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int         IDLE_LIMIT = 2000;
    localparam int         DRAIN_WAIT = 40;
    localparam longint     ACC_TOP    = 64'sh7FFF_FFFF_FFFF;
    localparam longint     ACC_BOTTOM = -ACC_TOP - 1;

    typedef struct {
        logic               linear;
        logic        [15:0] src;
        logic signed [16:0] dst;
        logic signed [31:0] pa;
        logic signed [31:0] slope;
        logic signed [31:0] qa;
        logic signed [31:0] qb;
    } curve_cfg_t;

    typedef struct packed {
        t_pix_in  px;
        logic     known;
        t_pix_out res;
    } dir_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_pix_in               i_pixel;
    logic                  o_valid;
    t_pix_out              o_result;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    curve_cfg_t curve;
    t_pix_out   pending_pixels[$];
    int         err_count;
    int         idle_cycles;

    // Directed pixels; the known rows follow from the identity curve at reset.
    dir_row_t dir_rows [12] = '{
        '{'{16'd0, 16'sh7FFF, 16'sh8000}, 1'b1, '{16'd0, 16'sh0000, 16'sh0000, 16'd0}},
        '{'{16'd0, 16'sh0000, 16'sh0000}, 1'b1, '{16'd0, 16'sh0000, 16'sh0000, 16'd0}},
        '{'{16'd32768, 16'sh7FFF, 16'sh8000}, 1'b1,
          '{16'd32768, 16'sh7FFF, 16'sh8000, 16'd32768}},
        '{'{16'd65535, 16'sh8000, 16'sh7FFF}, 1'b1,
          '{16'd65535, 16'sh8000, 16'sh7FFF, 16'd32768}},
        '{'{16'd65535, 16'shFFFF, 16'sh0001}, 1'b1,
          '{16'd65535, 16'shFFFF, 16'sh0001, 16'd32768}},
        '{'{16'd1, 16'sh1234, 16'shFFFF}, 1'b0, '0},
        '{'{16'd32767, 16'sh4000, 16'shC000}, 1'b0, '0},
        '{'{16'd32769, 16'sh0001, 16'sh7FFF}, 1'b0, '0},
        '{'{16'hAAAA, 16'sh5555, 16'shAAAA}, 1'b0, '0},
        '{'{16'h5555, 16'shAAAA, 16'sh5555}, 1'b0, '0},
        '{'{16'd100, 16'sh8000, 16'sh8000}, 1'b0, '0},
        '{'{16'd50000, 16'sh7FFF, 16'sh7FFF}, 1'b0, '0}
    };

    knee_tone_curve_with_desaturation_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Shift right with rounding to nearest, ties toward plus infinity.
    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_acc(longint v);
        if (v > ACC_TOP) return ACC_TOP;
        if (v < ACC_BOTTOM) return ACC_BOTTOM;
        return v;
    endfunction

    // Rounded num / den in Q1.15, saturated to the 16-bit range.
    function automatic logic [15:0] ratio_q15(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        if (num >= 2 * den) return 16'hFFFF;
        q = num / den;
        r = num % den;
        for (int i = 0; i < 16; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
        end
        q = (q + 1) >> 1;
        return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    // Gamut hull v(3-v)^2 in Q.48.
    function automatic longint unsigned hull_q48(logic [15:0] v);
        longint unsigned d;
        d = 64'd196608 - v;
        return d * d * v;
    endfunction

    function automatic logic signed [15:0] desat_chroma(logic signed [15:0] c,
                                                        logic [15:0] f);
        longint p;
        p = round_shift(longint'(c) * longint'({48'd0, f}), 15);
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        return p[15:0];
    endfunction

    // Expected result of one pixel under the current curve setting.
    function automatic t_pix_out map_pixel(t_pix_in px);
        t_pix_out        r;
        longint          s;
        longint          x;
        longint          acc;
        longint          y;
        logic     [15:0] f;
        s = longint'(curve.slope);
        if (curve.linear) begin
            y = round_shift(s * longint'({48'd0, px.intensity_in}), 16) + longint'(curve.dst);
        end else begin
            x = longint'({48'd0, px.intensity_in}) - longint'({48'd0, curve.src});
            if (x > 0) begin
                acc = clamp_acc(round_shift(longint'(curve.qa) * x, 16) + longint'(curve.qb));
                acc = clamp_acc(round_shift(acc * x, 16) + s);
            end else begin
                acc = clamp_acc(round_shift(longint'(curve.pa) * x, 16) + s);
            end
            y = round_shift(acc * x, 16) + longint'(curve.dst);
        end
        if (y < 0) y = 0;
        if (y > 65535) y = 65535;
        r.intensity_out = y[15:0];
        if (px.intensity_in == 0 || r.intensity_out == 0) begin
            f = '0;
        end else begin
            f = ratio_q15(px.intensity_in, r.intensity_out);
            if (ratio_q15(hull_q48(r.intensity_out), hull_q48(px.intensity_in)) < f)
                f = ratio_q15(hull_q48(r.intensity_out), hull_q48(px.intensity_in));
        end
        r.desat_factor = f;
        r.chroma_p_out = desat_chroma(px.chroma_p_in, f);
        r.chroma_t_out = desat_chroma(px.chroma_t_in, f);
        return r;
    endfunction

    // Check each result against the oldest expected one.
    always @(posedge i_clk) begin
        t_pix_out want;
        if (i_rst_n && o_valid) begin
            if (pending_pixels.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("ERROR: result %h with nothing expected", o_result);
            end else begin
                want = pending_pixels.pop_front();
                if (want.intensity_out !== o_result.intensity_out ||
                    want.chroma_p_out !== o_result.chroma_p_out ||
                    want.chroma_t_out !== o_result.chroma_t_out ||
                    want.desat_factor !== o_result.desat_factor) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("ERROR: I/P/T/F expected %h %h %h %h, got %h %h %h %h",
                                 want.intensity_out, want.chroma_p_out,
                                 want.chroma_t_out, want.desat_factor,
                                 o_result.intensity_out, o_result.chroma_p_out,
                                 o_result.chroma_t_out, o_result.desat_factor);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake at all.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_knee_tone_curve_with_desaturation_unit: errors");
            $finish;
        end
    end

    // Offer one item and hold it until accepted; the expectation is taken
    // from the setting in force at acceptance.
    task automatic send_pixel(t_pix_in px, logic known, t_pix_out res);
        @(negedge i_clk);
        start   = 1'b1;
        i_pixel = px;
        do @(posedge i_clk); while (busy);
        pending_pixels.push_back(known ? res : map_pixel(px));
    endtask

    task automatic hold_off(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    // Wait until every result is back and the pipeline is empty.
    task automatic drain();
        hold_off(1);
        while (pending_pixels.size() != 0) @(negedge i_clk);
        hold_off(DRAIN_WAIT);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        start       = 1'b0;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_LINEAR_MODE: curve.linear = data[0];
            CFG_SRC_KNEE:    curve.src    = data[15:0];
            CFG_DST_KNEE:    curve.dst    = data[16:0];
            CFG_PA:          curve.pa     = data;
            CFG_SLOPE:       curve.slope  = data;
            CFG_QA:          curve.qa     = data;
            CFG_QB:          curve.qb     = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Load a whole curve setting; a write to the unused index goes first.
    task automatic load_curve(curve_cfg_t c);
        drain();
        write_reg(CFG_UNUSED, $urandom);
        write_reg(CFG_LINEAR_MODE, {31'd0, c.linear});
        write_reg(CFG_SRC_KNEE, {16'd0, c.src});
        write_reg(CFG_DST_KNEE, {{15{c.dst[16]}}, c.dst});
        write_reg(CFG_PA, c.pa);
        write_reg(CFG_SLOPE, c.slope);
        write_reg(CFG_QA, c.qa);
        write_reg(CFG_QB, c.qb);
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 262143) - 131072;
        endcase
    endfunction

    function automatic t_pix_in rand_pixel();
        t_pix_in px;
        px.intensity_in = 16'($urandom);
        px.chroma_p_in  = 16'($urandom);
        px.chroma_t_in  = 16'($urandom);
        case ($urandom_range(0, 9))
            0: px.intensity_in = '0;
            1: px.intensity_in = 16'hFFFF;
            2: px.intensity_in = 16'(32'(curve.src) + $urandom_range(0, 4) - 2);
            default: ;
        endcase
        if ($urandom_range(0, 9) == 0) px.chroma_p_in = 16'sh8000;
        if ($urandom_range(0, 9) == 0) px.chroma_t_in = 16'sh7FFF;
        return px;
    endfunction

    // Random items in bursts, with gaps, long unbroken stretches and, at
    // random, pauses until every result is back.
    task automatic pixel_run(int count);
        int burst;
        while (count > 0) begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst && count > 0; i++) begin
                send_pixel(rand_pixel(), 1'b0, '0);
                count--;
            end
            case ($urandom_range(0, 9))
                0: drain();
                1, 2, 3: ;
                default: hold_off($urandom_range(1, 8));
            endcase
        end
    endtask

    initial begin
        curve_cfg_t c;
        start       = 1'b0;
        i_pixel     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        err_count   = 0;
        curve       = '{1'b0, 16'd32768, 17'sd32768, 32'sd0, 32'sd65536, 32'sd0, 32'sd0};
        i_rst_n     = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed pixels on the reset curve.
        foreach (dir_rows[i])
            send_pixel(dir_rows[i].px, dir_rows[i].known, dir_rows[i].res);
        pixel_run(20);

        // Linear, offset at its minimum: low intensities clamp to zero.
        load_curve('{1'b1, 16'd0, 17'h1_0000, 32'sd0, 32'sd131072, 32'sd0, 32'sd0});
        pixel_run(50);
        // Linear, scale and offset at their maxima: output saturates high.
        load_curve('{1'b1, 16'hFFFF, 17'sd65535, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF});
        pixel_run(40);
        load_curve('{1'b1, 16'd0, 17'sd65535, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000});
        pixel_run(40);
        // Knee at zero with coefficients that drive the sums into saturation.
        load_curve('{1'b0, 16'd0, 17'sd0, 32'sd0, 32'sd65536, 32'h8000_0000,
                     32'h7FFF_FFFF});
        pixel_run(50);
        load_curve('{1'b0, 16'hFFFF, 17'h1_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'sd0, 32'sd0});
        pixel_run(40);
        // A plausible compressing curve.
        load_curve('{1'b0, 16'd20000, 17'sd15000, -32'sd20000, 32'sd49152,
                     32'sd3000, -32'sd30000});
        pixel_run(60);

        // Random settings.
        repeat (7) begin
            c.linear = ($urandom_range(0, 3) == 0);
            c.src    = 16'($urandom);
            c.dst    = 17'($urandom);
            c.pa     = rand_coef();
            c.slope  = ($urandom_range(0, 1) == 0) ? $urandom_range(16384, 131072)
                                                    : rand_coef();
            c.qa     = rand_coef();
            c.qb     = rand_coef();
            load_curve(c);
            pixel_run(50);
        end

        drain();
        if (err_count == 0) begin
            $display("tb_knee_tone_curve_with_desaturation_unit: clean");
        end else begin
            $display("tb_knee_tone_curve_with_desaturation_unit: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

[knee_tone_curve_with_desaturation_unit.f]
+incdir+rtl
rtl/ktc_pkg.sv
rtl/ktc_div_pipe.sv
rtl/knee_tone_curve_with_desaturation_unit.sv
tb/tb_knee_tone_curve_with_desaturation_unit.sv
